[rtl/start_delimited_frame_parser_defines.svh]
// ----------------------------------------------------------------------------
// Start-delimited frame parser assertion macros
// Concurrent assertion wrappers, clocked on clk; compiled out by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef START_DELIMITED_FRAME_PARSER_DEFINES_SVH
`define START_DELIMITED_FRAME_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SDFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDFP_ASSERT(lbl, prop, msg)
`define SDFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/sdfp_pkg.sv]
// ----------------------------------------------------------------------------
// Start-delimited frame parser package
// Shared types and constants for the frame parser.
// ----------------------------------------------------------------------------
package sdfp_pkg;

    localparam int PAYLOAD_BYTES = 12;
    localparam int MARKER_BYTES  = 4;
    localparam int CNT_W         = 4;
    localparam int WORD_W        = 32;

    localparam logic [7:0]        START_BYTE_RST = 8'h7E;
    localparam logic [WORD_W-1:0] END_MARKER_RST = 32'h7FFF_FFFF;

    typedef enum logic [0:0] {
        REG_START_BYTE = 1'b0,
        REG_END_MARKER = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_MARKER  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_END   = 2'd1,
        ST_BAD_START = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_one;
        logic signed [WORD_W-1:0] word_two;
        logic signed [WORD_W-1:0] word_three;
        status_t                  status;
    } result_t;

endpackage

[rtl/sdfp_collector.sv]
// ----------------------------------------------------------------------------
// Frame collector
// Hunts for the start byte, shifts in payload and marker bytes, and forms
// the result for the byte that ends or rejects a frame.
// ----------------------------------------------------------------------------
module sdfp_collector (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic [7:0]              rx_byte,
    input  logic [7:0]              start_byte,
    input  logic [31:0]             end_marker,
    output logic                    res_valid,
    output sdfp_pkg::result_t       res
);
    import sdfp_pkg::*;

    localparam int PAY_W = PAYLOAD_BYTES * 8;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PAY_W-1:0]  payload_reg;
    logic [WORD_W-1:0] marker_reg;
    logic [WORD_W-1:0] marker_full;

    assign marker_full = {marker_reg[WORD_W-9:0], rx_byte};

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (take)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    if (count_reg == CNT_W'(PAYLOAD_BYTES - 1))
                    begin
                        phase_next = PH_MARKER;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                PH_MARKER:
                begin
                    if (count_reg == CNT_W'(MARKER_BYTES - 1))
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    count_next = '0;
                    phase_next = (rx_byte == start_byte) ? PH_PAYLOAD : PH_HUNT;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        res_valid      = 1'b0;
        res.word_one   = '0;
        res.word_two   = '0;
        res.word_three = '0;
        res.status     = ST_OK;
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                res_valid = 1'b0;
            end
            PH_MARKER:
            begin
                if (take && count_reg == CNT_W'(MARKER_BYTES - 1))
                begin
                    res_valid = 1'b1;
                    if (marker_full == end_marker)
                    begin
                        res.word_one   = payload_reg[PAY_W-1 -: WORD_W];
                        res.word_two   = payload_reg[PAY_W-WORD_W-1 -: WORD_W];
                        res.word_three = payload_reg[WORD_W-1:0];
                        res.status     = ST_OK;
                    end
                    else
                    begin
                        res.status = ST_BAD_END;
                    end
                end
            end
            default:
            begin
                if (take && rx_byte != start_byte)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_BAD_START;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // byte shift lines, big-endian
    always_ff @(posedge clk)
    begin
        if (take && phase_reg == PH_PAYLOAD)
        begin
            payload_reg <= {payload_reg[PAY_W-9:0], rx_byte};
        end
        if (take && phase_reg == PH_MARKER)
        begin
            marker_reg <= marker_full;
        end
    end

endmodule

[rtl/start_delimited_frame_parser.sv]
// ----------------------------------------------------------------------------
// Start-delimited frame parser
// Parses start byte, 12 payload bytes and a 4-byte end marker into three
// signed words, with status words for bad starts and bad markers.
//
//  channel  signals                          word
//  in       in_valid / in_ready              rx_byte
//  out      out_valid / out_ready            word_one..three, frame_status
//  cfg      cfg_write, cfg_index, cfg_data   start_byte, end_marker
//
// One byte per cycle while in_ready is high; a result is formed from its last byte and registered.
// Reset: hunting, start_byte 0x7E, end_marker 0x7FFFFFFF.
// An output register plus one skid entry keep input taking bytes while a
// result waits; in_ready drops only while the skid entry is full.
// ----------------------------------------------------------------------------
module start_delimited_frame_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] word_one,
    output logic signed [31:0] word_two,
    output logic signed [31:0] word_three,
    output logic [1:0]         frame_status,
    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import sdfp_pkg::*;

    logic [7:0]        start_byte_reg;
    logic [WORD_W-1:0] end_marker_reg;
    logic              take;
    logic              res_valid;
    result_t           res;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    result_t           out_reg, out_next;
    result_t           skid_reg, skid_next;
    logic              pop;

    assign in_ready = !skid_valid_reg;
    assign take     = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            end_marker_reg <= END_MARKER_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_START_BYTE: start_byte_reg <= cfg_data[7:0];
                REG_END_MARKER: end_marker_reg <= cfg_data;
                default:        start_byte_reg <= start_byte_reg;
            endcase
        end
    end

    sdfp_collector u_collector (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .rx_byte    (rx_byte),
        .start_byte (start_byte_reg),
        .end_marker (end_marker_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            out_valid_next = skid_valid_reg;
            out_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (res_valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_next       = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign word_one     = out_reg.word_one;
    assign word_two     = out_reg.word_two;
    assign word_three   = out_reg.word_three;
    assign frame_status = out_reg.status;

`include "start_delimited_frame_parser_defines.svh"

    `SDFP_ASSERT_ALWAYS(a_skid_needs_out, (!rst_n || !skid_valid_reg || out_valid_reg), "skid word without output word")
    `SDFP_ASSERT(a_bad_words_zero, (out_valid && frame_status != ST_OK) |-> (word_one == 0 && word_two == 0 && word_three == 0), "error word carries payload")
    `SDFP_ASSERT(a_status_code, out_valid |-> (frame_status == ST_OK || frame_status == ST_BAD_END || frame_status == ST_BAD_START), "reserved status code")

endmodule
